FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising edge while out of reset
`define VMT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vmt check failed");

// checked on every rising edge, reset included
`define VMT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("vmt check failed");

`else

`define VMT_ASSERT(lbl, clk, rst_n, prop)
`define VMT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/vmt_pkg.sv
package vmt_pkg;

	localparam int unsigned NUM_ROWS    = 4;
	localparam int unsigned NUM_COLS    = 4;
	localparam int unsigned NRM_DIM     = 3;
	localparam int unsigned COORD_W     = 32;
	localparam int unsigned ENTRY_W     = 16;
	localparam int unsigned ROW_W       = NUM_COLS * ENTRY_W;
	localparam int unsigned PROD_W      = COORD_W + ENTRY_W;
	localparam int unsigned SUM_W       = PROD_W + 2;
	localparam int unsigned FRAC_SHIFT  = 12;
	localparam int unsigned CFG_IDX_W   = 3;

	localparam logic [ROW_W-1:0] ROW0_RST = 64'h1000_0000_0000_0000;
	localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_1000_0000_0000;
	localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW3_RST = 64'h0000_0000_0000_1000;

	localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef logic [ROW_W-1:0] mat_row_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x_in;
		logic signed [COORD_W-1:0] pos_y_in;
		logic signed [COORD_W-1:0] pos_z_in;
		logic signed [COORD_W-1:0] pos_w_in;
		logic signed [COORD_W-1:0] norm_x_in;
		logic signed [COORD_W-1:0] norm_y_in;
		logic signed [COORD_W-1:0] norm_z_in;
		logic signed [COORD_W-1:0] tex_u_in;
		logic signed [COORD_W-1:0] tex_v_in;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x_out;
		logic signed [COORD_W-1:0] pos_y_out;
		logic signed [COORD_W-1:0] pos_z_out;
		logic signed [COORD_W-1:0] pos_w_out;
		logic signed [COORD_W-1:0] norm_x_out;
		logic signed [COORD_W-1:0] norm_y_out;
		logic signed [COORD_W-1:0] norm_z_out;
		logic signed [COORD_W-1:0] tex_u_out;
		logic signed [COORD_W-1:0] tex_v_out;
		logic                      overflow_flag;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] val;
		logic                      ovf;
	} sat_t;

	// round a q22.28 sum to q16.16 (ties toward +inf), then clamp to 32 bits
	function automatic sat_t round_sat(input logic signed [SUM_W-1:0] sum);
		logic signed [SUM_W:0]                 biased;
		logic signed [SUM_W-FRAC_SHIFT:0]      q;
		sat_t                                  r;
		biased = (SUM_W+1)'(sum) + (SUM_W+1)'(signed'(2 ** (FRAC_SHIFT - 1)));
		q      = (SUM_W-FRAC_SHIFT+1)'(biased >>> FRAC_SHIFT);
		if (q > (SUM_W-FRAC_SHIFT+1)'(SAT_MAX)) begin
			r.val = SAT_MAX;
			r.ovf = 1'b1;
		end else if (q < (SUM_W-FRAC_SHIFT+1)'(SAT_MIN)) begin
			r.val = SAT_MIN;
			r.ovf = 1'b1;
		end else begin
			r.val = COORD_W'(q);
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/vertex_matrix_transform.sv
// channel  | handshake                | payload              | role
// ---------+--------------------------+----------------------+-------------------------------
// vert     | vert_valid / vert_stall  | vertex_t             | vertex request in
// xfm      | xfm_valid  / xfm_stall   | result_t             | transformed vertex request out
// cfg      | cfg_we                   | cfg_idx, cfg_wdata   | matrix row write, idx 4+ dropped
//
// one vertex request is taken per cycle, back to back, while vert_stall is low
// after the accepting edge a request loads the input register, then the
// product register (25 multipliers of 16 x 32 bits), then the result register
// with sum, round, clamp; xfm_valid rises as the result register is loaded
// the three stages move together; a stalled, full result register holds the
// whole pipe, so vert_stall follows xfm_stall only while xfm_valid is high
// reset loads the identity matrix and empties every stage

`include "assert_macros.svh"

module vertex_matrix_transform
	import vmt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 vert_valid,
	output logic                 vert_stall,
	input  vertex_t              vert_data,

	output logic                 xfm_valid,
	input  logic                 xfm_stall,
	output result_t              xfm_data,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [ROW_W-1:0]     cfg_wdata
);

	// matrix rows
	mat_row_t mat_q [NUM_ROWS];

	// pipe control
	logic    adv;
	logic    valid_s1;
	logic    valid_s2;
	logic    xfm_valid_q;

	// stage 1: captured vertex
	vertex_t vert_s1;

	// stage 2: products and pass-through coordinates
	logic signed [PROD_W-1:0]  pos_prod_s2 [NUM_ROWS][NUM_COLS];
	logic signed [PROD_W-1:0]  nrm_prod_s2 [NRM_DIM][NRM_DIM];
	logic signed [COORD_W-1:0] tex_u_s2;
	logic signed [COORD_W-1:0] tex_v_s2;

	// stage 3: result register
	result_t xfm_data_q;

	// coordinate views of the stage 1 vertex
	logic signed [COORD_W-1:0] pos_s1 [NUM_COLS];
	logic signed [COORD_W-1:0] nrm_s1 [NRM_DIM];

	// combinational finish
	logic signed [SUM_W-1:0] pos_sum [NUM_ROWS];
	logic signed [SUM_W-1:0] nrm_sum [NRM_DIM];
	sat_t                    pos_sat [NUM_ROWS];
	sat_t                    nrm_sat [NRM_DIM];
	result_t                 res_next;

	// whole pipe moves unless a finished result is waiting and stalled
	assign adv        = !(xfm_valid_q && xfm_stall);
	assign vert_stall = !adv;
	assign xfm_valid  = xfm_valid_q;
	assign xfm_data   = xfm_data_q;

	// configuration writes, out-of-range indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= ROW0_RST;
			mat_q[1] <= ROW1_RST;
			mat_q[2] <= ROW2_RST;
			mat_q[3] <= ROW3_RST;
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_ROWS))) begin
			mat_q[cfg_idx[$clog2(NUM_ROWS)-1:0]] <= cfg_wdata;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			xfm_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= vert_valid;
			valid_s2    <= valid_s1;
			xfm_valid_q <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv && vert_valid) begin
			vert_s1 <= vert_data;
		end
	end

	assign pos_s1[0] = vert_s1.pos_x_in;
	assign pos_s1[1] = vert_s1.pos_y_in;
	assign pos_s1[2] = vert_s1.pos_z_in;
	assign pos_s1[3] = vert_s1.pos_w_in;
	assign nrm_s1[0] = vert_s1.norm_x_in;
	assign nrm_s1[1] = vert_s1.norm_y_in;
	assign nrm_s1[2] = vert_s1.norm_z_in;

	// product stage: one multiplier per matrix entry and coordinate
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_pos_row
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_pos_col
			logic signed [ENTRY_W-1:0] ent;
			assign ent = signed'(mat_q[r][(NUM_COLS-1-c)*ENTRY_W +: ENTRY_W]);
			always_ff @(posedge clk) begin
				if (adv && valid_s1) begin
					pos_prod_s2[r][c] <= PROD_W'(ent) * PROD_W'(pos_s1[c]);
				end
			end
		end
	end

	// normal uses the upper 3x3 only (w taken as zero)
	for (genvar r = 0; r < NRM_DIM; r++) begin : g_nrm_row
		for (genvar c = 0; c < NRM_DIM; c++) begin : g_nrm_col
			logic signed [ENTRY_W-1:0] ent;
			assign ent = signed'(mat_q[r][(NUM_COLS-1-c)*ENTRY_W +: ENTRY_W]);
			always_ff @(posedge clk) begin
				if (adv && valid_s1) begin
					nrm_prod_s2[r][c] <= PROD_W'(ent) * PROD_W'(nrm_s1[c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			tex_u_s2 <= vert_s1.tex_u_in;
			tex_v_s2 <= vert_s1.tex_v_in;
		end
	end

	// row sums, rounding and clamping
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			pos_sum[r] = SUM_W'(pos_prod_s2[r][0]) + SUM_W'(pos_prod_s2[r][1])
				+ SUM_W'(pos_prod_s2[r][2]) + SUM_W'(pos_prod_s2[r][3]);
			pos_sat[r] = round_sat(pos_sum[r]);
		end
		for (int r = 0; r < NRM_DIM; r++) begin
			nrm_sum[r] = SUM_W'(nrm_prod_s2[r][0]) + SUM_W'(nrm_prod_s2[r][1])
				+ SUM_W'(nrm_prod_s2[r][2]);
			nrm_sat[r] = round_sat(nrm_sum[r]);
		end
	end

	always_comb begin
		res_next.pos_x_out     = pos_sat[0].val;
		res_next.pos_y_out     = pos_sat[1].val;
		res_next.pos_z_out     = pos_sat[2].val;
		res_next.pos_w_out     = pos_sat[3].val;
		res_next.norm_x_out    = nrm_sat[0].val;
		res_next.norm_y_out    = nrm_sat[1].val;
		res_next.norm_z_out    = nrm_sat[2].val;
		res_next.tex_u_out     = tex_u_s2;
		res_next.tex_v_out     = tex_v_s2;
		res_next.overflow_flag = pos_sat[0].ovf | pos_sat[1].ovf | pos_sat[2].ovf
			| pos_sat[3].ovf | nrm_sat[0].ovf | nrm_sat[1].ovf | nrm_sat[2].ovf;
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			xfm_data_q <= res_next;
		end
	end

	// an accepted request lands in stage 1
	`VMT_ASSERT(a_accept_fills_s1, clk, arst_n,
		(vert_valid && !vert_stall) |=> valid_s1)

	// stage 2 content moves into the result register when the pipe advances
	`VMT_ASSERT(a_s2_to_result, clk, arst_n,
		(valid_s2 && adv) |=> xfm_valid)

	// a flagged overflow always shows a clamped component
	`VMT_ASSERT(a_ovf_has_clamp, clk, arst_n,
		(xfm_valid && xfm_data.overflow_flag) |->
		(xfm_data.pos_x_out == SAT_MAX || xfm_data.pos_x_out == SAT_MIN ||
		 xfm_data.pos_y_out == SAT_MAX || xfm_data.pos_y_out == SAT_MIN ||
		 xfm_data.pos_z_out == SAT_MAX || xfm_data.pos_z_out == SAT_MIN ||
		 xfm_data.pos_w_out == SAT_MAX || xfm_data.pos_w_out == SAT_MIN ||
		 xfm_data.norm_x_out == SAT_MAX || xfm_data.norm_x_out == SAT_MIN ||
		 xfm_data.norm_y_out == SAT_MAX || xfm_data.norm_y_out == SAT_MIN ||
		 xfm_data.norm_z_out == SAT_MAX || xfm_data.norm_z_out == SAT_MIN))

	// stage 2 never drops its request while the pipe is held
	`VMT_ASSERT_ALWAYS(a_hold_keeps_s2, clk,
		(arst_n && valid_s2 && !adv) |=> (!arst_n || valid_s2))

endmodule
